/* src/life_generation_torus_defines.svh */
// Assertion macros shared by the life_generation_torus RTL.
`ifndef LIFE_GENERATION_TORUS_DEFINES_SVH
`define LIFE_GENERATION_TORUS_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define LGT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("life_generation_torus: implication check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define LGT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("life_generation_torus: next-cycle check failed");

`endif

/* src/lgt_pkg.sv */
// Shared types, constants and helpers of the toroidal Life engine.
`timescale 1ns / 1ps

package lgt_pkg;

    localparam int CELLS_W      = 64;
    localparam int IDX_W        = 6;
    localparam int REQ_W        = 2;
    localparam int SIZE_W       = 7;
    localparam int CFG_IDX_W    = 1;
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd32;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 7'd3;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ADVANCE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COLS = 1'b1;

    // Neighbor count (or'ed with the cell's own bit) that yields a live cell.
    localparam logic [3:0] LIFE_SUM = 4'd3;

    typedef struct packed {
        logic shift;   // push a new row bit into the vertical window
        logic active;  // column lies inside the active region
    } cell_ctrl_t;

    // Saturate a size register to the range 3..maxv.
    function automatic logic [SIZE_W-1:0] clamp_size(
        input logic [SIZE_W-1:0] v,
        input logic [SIZE_W-1:0] maxv
    );
        logic [SIZE_W-1:0] res;
        if (v < SIZE_MIN) begin
            res = SIZE_MIN;
        end
        else if (v > maxv) begin
            res = maxv;
        end
        else begin
            res = v;
        end
        return res;
    endfunction

endpackage

/* src/lgt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lgt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/lgt_cell.sv */
// One column cell: a three-row vertical window and the Life rule for its column.
`timescale 1ns / 1ps

module lgt_cell (
    input  logic                clk,
    input  lgt_pkg::cell_ctrl_t ctrl,
    input  logic                din,
    input  logic [1:0]          vsum_left,
    input  logic [1:0]          vsum_right,
    output logic [1:0]          vsum,
    output logic                new_bit
);

    import lgt_pkg::*;

    logic up_reg, mid_reg, down_reg;
    logic up_next, mid_next, down_next;
    logic [3:0] nbr_count;

    always_comb
    begin
        up_next   = ctrl.shift ? mid_reg  : up_reg;
        mid_next  = ctrl.shift ? down_reg : mid_reg;
        down_next = ctrl.shift ? din      : down_reg;
    end

    always_ff @(posedge clk)
    begin
        up_reg   <= up_next;
        mid_reg  <= mid_next;
        down_reg <= down_next;
    end

    // Column sum handed to both horizontal neighbors.
    assign vsum = 2'(up_reg) + 2'(mid_reg) + 2'(down_reg);

    assign nbr_count = 4'(vsum_left) + 4'(vsum_right) + 4'(up_reg) + 4'(down_reg);

    assign new_bit = ctrl.active && ((nbr_count | 4'(mid_reg)) == LIFE_SUM);

endmodule

/* src/life_generation_torus.sv */
// Top level of the toroidal Life engine: request control, row store and cell row.
//
//   channel   direction  handshake               payload
//   in        input      in_valid / in_ready     req_type, row_index, row_cells
//   out       output     out_valid / out_ready   out_row_index, out_row_cells, last_row
//   cfg       input      cfg_we                  cfg_index, cfg_data
//
// A row read passes through the registered read of the row store before it reaches the
// output register. An advance is paced by the single read port of the row store, which
// delivers one row per cycle to the cell row while the output register can take results.
// After reset every row reads as zero through per-row valid flags; no clearing pass.
// When a result waits in the output register and is not taken, the whole advance
// pipeline holds, including the row store read, until the transfer completes.
`timescale 1ns / 1ps

module life_generation_torus #(
    parameter int MAX_ROWS = lgt_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = lgt_pkg::MAX_COLS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lgt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lgt_pkg::SIZE_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [lgt_pkg::REQ_W-1:0]       req_type,
    input  logic [lgt_pkg::IDX_W-1:0]       row_index,
    input  logic [lgt_pkg::CELLS_W-1:0]     row_cells,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [lgt_pkg::IDX_W-1:0]       out_row_index,
    output logic [lgt_pkg::CELLS_W-1:0]     out_row_cells,
    output logic                            last_row
);

    import lgt_pkg::*;

    `include "life_generation_torus_defines.svh"

    localparam int AW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_ADV
    } state_t;

    // Registers.
    state_t                state_reg, state_next;
    logic [SIZE_W-1:0]     rows_cfg_reg, rows_cfg_next;
    logic [SIZE_W-1:0]     cols_cfg_reg, cols_cfg_next;
    logic [SIZE_W-1:0]     step_reg, step_next;
    logic [MAX_COLS-1:0]   top_reg, top_next;
    logic [MAX_ROWS-1:0]   row_valid_reg, row_valid_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  rd_in_range_reg, rd_in_range_next;
    logic                  out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]      out_idx_reg, out_idx_next;
    logic [CELLS_W-1:0]    out_cells_reg, out_cells_next;
    logic                  out_last_reg, out_last_next;

    // Row store ports.
    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [MAX_COLS-1:0]   ram_wdata, ram_rdata;
    logic [MAX_COLS-1:0]   rdata_masked;

    // Control and cell row.
    logic                  en;
    logic                  in_xfer;
    logic                  in_range;
    logic                  out_load;
    logic                  emit;
    logic                  emit_last;
    logic [SIZE_W-1:0]     emit_y;
    logic [SIZE_W-1:0]     rows_eff, cols_eff, cols_m1;
    logic                  shift;
    logic [MAX_COLS-1:0]   shift_data;
    logic [MAX_COLS-1:0]   new_row;
    logic [1:0]            vsum [MAX_COLS];

    // Address of the last active row, used as the row above row zero.
    function automatic logic [AW-1:0] last_active_row(input logic [SIZE_W-1:0] rows);
        logic [SIZE_W-1:0] last;
        last = rows - SIZE_W'(1);
        return last[AW-1:0];
    endfunction

    assign rows_eff = clamp_size(rows_cfg_reg, SIZE_W'(MAX_ROWS));
    assign cols_eff = clamp_size(cols_cfg_reg, SIZE_W'(MAX_COLS));
    assign cols_m1  = cols_eff - SIZE_W'(1);

    // The pipeline moves whenever the output register can take a new result.
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign in_range = ({1'b0, row_index} < SIZE_W'(MAX_ROWS));

    // A row that was never written since reset reads as all dead cells.
    assign rdata_masked = rd_valid_reg ? ram_rdata : '0;

    // Advance schedule, counted by step t from zero:
    //   t = 0 .. rows       read the row store: row rows-1 first, then rows 0 .. rows-1.
    //   t = 1 .. rows+2     shift the row read at the step before into the cells; the
    //                       last shift repeats the original top row kept in top_reg.
    //   t = 4 .. rows+3     the cells hold rows y-1, y, y+1 with y = t-4; the new row y
    //                       is written back in place and loaded into the output register.
    // Each write-back lands on a row that is never read again in this generation.
    always_comb
    begin
        state_next       = state_reg;
        rows_cfg_next    = rows_cfg_reg;
        cols_cfg_next    = cols_cfg_reg;
        step_next        = step_reg;
        top_next         = top_reg;
        row_valid_next   = row_valid_reg;
        rd_valid_next    = rd_valid_reg;
        rd_idx_next      = rd_idx_reg;
        rd_in_range_next = rd_in_range_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_idx_next     = out_idx_reg;
        out_cells_next   = out_cells_reg;
        out_last_next    = out_last_reg;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = '0;
        ram_re           = 1'b0;
        ram_raddr        = '0;
        shift            = 1'b0;
        shift_data       = rdata_masked;
        out_load         = 1'b0;
        emit             = 1'b0;
        emit_last        = 1'b0;
        emit_y           = step_reg - SIZE_W'(4);

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ACTIVE_ROWS: rows_cfg_next = cfg_data;
                REG_ACTIVE_COLS: cols_cfg_next = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    unique case (req_type)
                        REQ_WRITE:
                        begin
                            if (in_range)
                            begin
                                ram_we                    = 1'b1;
                                ram_waddr                 = row_index[AW-1:0];
                                ram_wdata                 = row_cells[MAX_COLS-1:0];
                                row_valid_next[ram_waddr] = 1'b1;
                            end
                        end
                        REQ_READ:
                        begin
                            ram_re           = in_range;
                            ram_raddr        = row_index[AW-1:0];
                            rd_idx_next      = row_index;
                            rd_in_range_next = in_range;
                            state_next       = ST_READ;
                        end
                        REQ_ADVANCE:
                        begin
                            step_next  = '0;
                            state_next = ST_ADV;
                        end
                        default: ;
                    endcase
                end
            end

            ST_READ:
            begin
                if (en)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    out_idx_next   = rd_idx_reg;
                    out_cells_next = rd_in_range_reg ? CELLS_W'(rdata_masked) : '0;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_ADV:
            begin
                if (en)
                begin
                    step_next = step_reg + SIZE_W'(1);

                    if (step_reg <= rows_eff)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = (step_reg == '0) ? last_active_row(rows_eff)
                                                     : AW'(step_reg - SIZE_W'(1));
                    end

                    if ((step_reg >= SIZE_W'(1)) && (step_reg <= rows_eff + SIZE_W'(2)))
                    begin
                        shift = 1'b1;
                        if (step_reg == rows_eff + SIZE_W'(2))
                        begin
                            shift_data = top_reg;
                        end
                        if (step_reg == SIZE_W'(2))
                        begin
                            top_next = rdata_masked;
                        end
                    end

                    if (step_reg >= SIZE_W'(4))
                    begin
                        emit                      = 1'b1;
                        emit_last                 = (emit_y == rows_eff - SIZE_W'(1));
                        ram_we                    = 1'b1;
                        ram_waddr                 = emit_y[AW-1:0];
                        ram_wdata                 = new_row;
                        row_valid_next[ram_waddr] = 1'b1;
                        out_load                  = 1'b1;
                        out_valid_next            = 1'b1;
                        out_idx_next              = emit_y[IDX_W-1:0];
                        out_cells_next            = CELLS_W'(new_row);
                        out_last_next             = emit_last;
                        if (emit_last)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            default: state_next = ST_IDLE;
        endcase

        // The valid flag of the row being read travels with the registered read data.
        if (ram_re)
        begin
            rd_valid_next = row_valid_reg[ram_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rows_cfg_reg    <= SIZE_RESET;
            cols_cfg_reg    <= SIZE_RESET;
            step_reg        <= '0;
            top_reg         <= '0;
            row_valid_reg   <= '0;
            rd_valid_reg    <= 1'b0;
            rd_idx_reg      <= '0;
            rd_in_range_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_idx_reg     <= '0;
            out_cells_reg   <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            rows_cfg_reg    <= rows_cfg_next;
            cols_cfg_reg    <= cols_cfg_next;
            step_reg        <= step_next;
            top_reg         <= top_next;
            row_valid_reg   <= row_valid_next;
            rd_valid_reg    <= rd_valid_next;
            rd_idx_reg      <= rd_idx_next;
            rd_in_range_reg <= rd_in_range_next;
            out_valid_reg   <= out_valid_next;
            out_idx_reg     <= out_idx_next;
            out_cells_reg   <= out_cells_next;
            out_last_reg    <= out_last_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_row_index = out_idx_reg;
    assign out_row_cells = out_cells_reg;
    assign last_row      = out_last_reg;

    lgt_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_row_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Row of column cells. Each cell hands its column sum to both neighbors;
    // the wrap at the active column count closes the ring.
    for (genvar x = 0; x < MAX_COLS; x++)
    begin : g_col
        cell_ctrl_t  ctrl;
        logic [1:0]  vs_left;
        logic [1:0]  vs_right;

        // Fields in declaration order: shift, then active.
        assign ctrl = {shift, (SIZE_W'(x) < cols_eff)};

        if (x == 0)
        begin : g_left_wrap
            assign vs_left = vsum[cols_m1[CW-1:0]];
        end
        else
        begin : g_left
            assign vs_left = vsum[x-1];
        end

        if (x == MAX_COLS - 1)
        begin : g_right_wrap
            assign vs_right = vsum[0];
        end
        else
        begin : g_right
            assign vs_right = (SIZE_W'(x) == cols_m1) ? vsum[0] : vsum[x+1];
        end

        lgt_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .din        (shift_data[x]),
            .vsum_left  (vs_left),
            .vsum_right (vs_right),
            .vsum       (vsum[x]),
            .new_bit    (new_row[x])
        );
    end

    // The output register is only loaded when it is free or being emptied.
    `LGT_ASSERT_IMP(a_out_load_free, out_load, !out_valid_reg || out_ready)
    // A write-back never targets the row being read in the same cycle.
    `LGT_ASSERT_IMP(a_ports_apart, ram_we && ram_re, ram_waddr != ram_raddr)
    // Every emitted row of a generation lies inside the active rows.
    `LGT_ASSERT_IMP(a_emit_in_range, emit, emit_y < rows_eff)
    // The final row of a generation returns control to idle.
    `LGT_ASSERT_NXT(a_last_ends_adv, emit && emit_last, state_reg == ST_IDLE)

endmodule

/* test/life_generation_torus_tb.sv */
// Self-checking testbench for the toroidal Life engine: row writes, row reads and generation steps.
`timescale 1ns / 1ps

// One reported row as the block presents it on the output channel.
typedef struct packed {
    logic [lgt_pkg::IDX_W-1:0]   row;
    logic [lgt_pkg::CELLS_W-1:0] cells;
    logic                        last_flag;
} row_report_t;

// Shadow copy of the grid and its size registers, plus the rows the block still owes us.
class torus_mirror;
    logic [lgt_pkg::CELLS_W-1:0] grid_copy [lgt_pkg::MAX_ROWS_DEF];
    logic [lgt_pkg::SIZE_W-1:0]  rows_reg;
    logic [lgt_pkg::SIZE_W-1:0]  cols_reg;
    row_report_t                 due_rows [$];
    int errors;
    int shown;
    int writes;
    int reads;
    int advances;
    int ignored;
    int reports;
    int requests_taken;

    function new();
        rows_reg = lgt_pkg::SIZE_RESET;
        cols_reg = lgt_pkg::SIZE_RESET;
        foreach (grid_copy[i]) grid_copy[i] = '0;
        errors = 0;
        shown = 0;
        writes = 0;
        reads = 0;
        advances = 0;
        ignored = 0;
        reports = 0;
        requests_taken = 0;
    endfunction

    // Sizes outside 3..max are saturated when used; the register keeps what was written.
    function int fit_size(logic [lgt_pkg::SIZE_W-1:0] v, int maxv);
        int res;
        if (v < 3) res = 3;
        else if (v > maxv) res = maxv;
        else res = v;
        return res;
    endfunction

    function int rows_in_use();
        return fit_size(rows_reg, lgt_pkg::MAX_ROWS_DEF);
    endfunction

    function void set_size(logic [lgt_pkg::CFG_IDX_W-1:0] idx, logic [lgt_pkg::SIZE_W-1:0] value);
        if (idx == lgt_pkg::REG_ACTIVE_ROWS) rows_reg = value;
        else if (idx == lgt_pkg::REG_ACTIVE_COLS) cols_reg = value;
    endfunction

    // New value of one row; neighbors wrap at ncols, columns at or above ncols come out dead.
    function logic [lgt_pkg::CELLS_W-1:0] next_gen_row(logic [lgt_pkg::CELLS_W-1:0] up,
                                                       logic [lgt_pkg::CELLS_W-1:0] mid,
                                                       logic [lgt_pkg::CELLS_W-1:0] down,
                                                       int ncols);
        logic [lgt_pkg::CELLS_W-1:0] res;
        int x;
        int l;
        int r;
        int n;
        res = '0;
        for (x = 0; x < ncols; x++) begin
            l = (x == 0) ? ncols - 1 : x - 1;
            r = (x == ncols - 1) ? 0 : x + 1;
            n = int'(up[l]) + int'(up[x]) + int'(up[r]) + int'(mid[l]) + int'(mid[r])
              + int'(down[l]) + int'(down[x]) + int'(down[r]);
            if ((n | int'(mid[x])) == lgt_pkg::LIFE_SUM) res[x] = 1'b1;
        end
        return res;
    endfunction

    // The block updates in place with saved copies, which equals a step from the old grid.
    function void step_generation();
        logic [lgt_pkg::CELLS_W-1:0] old_rows [lgt_pkg::MAX_ROWS_DEF];
        row_report_t rep;
        int nrows;
        int ncols;
        int y;
        nrows = rows_in_use();
        ncols = fit_size(cols_reg, lgt_pkg::MAX_COLS_DEF);
        old_rows = grid_copy;
        for (y = 0; y < nrows; y++) begin
            grid_copy[y] = next_gen_row(old_rows[(y + nrows - 1) % nrows], old_rows[y],
                                        old_rows[(y + 1) % nrows], ncols);
            rep.row = y[lgt_pkg::IDX_W-1:0];
            rep.cells = grid_copy[y];
            rep.last_flag = (y == nrows - 1);
            due_rows.push_back(rep);
        end
    endfunction

    function void take_request(logic [lgt_pkg::REQ_W-1:0] req, logic [lgt_pkg::IDX_W-1:0] idx,
                               logic [lgt_pkg::CELLS_W-1:0] cells);
        row_report_t rep;
        requests_taken++;
        case (req)
            lgt_pkg::REQ_WRITE: begin
                grid_copy[idx] = cells;
                writes++;
            end
            lgt_pkg::REQ_READ: begin
                rep.row = idx;
                rep.cells = grid_copy[idx];
                rep.last_flag = 1'b1;
                due_rows.push_back(rep);
                reads++;
            end
            lgt_pkg::REQ_ADVANCE: begin
                step_generation();
                advances++;
            end
            default: ignored++;
        endcase
    endfunction

    function void complain(string what, logic [lgt_pkg::CELLS_W-1:0] want,
                           logic [lgt_pkg::CELLS_W-1:0] got);
        errors++;
        if (shown < 40) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
        else if (shown == 40) begin
            $display("%0t ns: further mismatches are counted but not shown", $time);
        end
        shown++;
    endfunction

    function void check_row(logic [lgt_pkg::IDX_W-1:0] idx, logic [lgt_pkg::CELLS_W-1:0] cells,
                            logic last_flag);
        row_report_t want;
        reports++;
        if (due_rows.size() == 0) begin
            errors++;
            if (shown < 40) begin
                $display("%0t ns: unexpected row report, expected none, actual row %0d cells %h",
                         $time, idx, cells);
            end
            shown++;
            return;
        end
        want = due_rows.pop_front();
        if (want.row !== idx) begin
            complain("out_row_index",
                     {{(lgt_pkg::CELLS_W - lgt_pkg::IDX_W){1'b0}}, want.row},
                     {{(lgt_pkg::CELLS_W - lgt_pkg::IDX_W){1'b0}}, idx});
        end
        if (want.cells !== cells) complain("out_row_cells", want.cells, cells);
        if (want.last_flag !== last_flag) begin
            complain("last_row",
                     {{(lgt_pkg::CELLS_W - 1){1'b0}}, want.last_flag},
                     {{(lgt_pkg::CELLS_W - 1){1'b0}}, last_flag});
        end
    endfunction
endclass

module life_generation_torus_tb;
    import lgt_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 10;
    localparam int ITEMS_PER_PHASE = 48;
    localparam int N_SETTINGS      = 8;
    // Idle wait after the last owed row; this covers the largest grid with margin.
    localparam int SETTLE_CYCLES   = 100;
    // The receiver's long hold-off starts once this many requests have gone in.
    localparam int HOLD_AFTER      = 180;
    localparam int LONG_HOLD       = 500;
    // Worst case is roughly 450 full-size advances against the slowest receiver pattern.
    localparam int CYCLE_LIMIT     = 800000;
    // Request type 3 has no meaning; the block must drop it without a trace.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [REQ_W-1:0]     req_type = '0;
    logic [IDX_W-1:0]     row_index = '0;
    logic [CELLS_W-1:0]   row_cells = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [IDX_W-1:0]     out_row_index;
    logic [CELLS_W-1:0]   out_row_cells;
    logic                 last_row;

    // Size settings for the random phases, extremes and out-of-range values among them.
    logic [SIZE_W-1:0] rows_plan [N_SETTINGS] = '{7'd3, 7'd64, 7'd0, 7'd127,
                                                  7'd5, 7'd64, 7'd17, 7'd2};
    logic [SIZE_W-1:0] cols_plan [N_SETTINGS] = '{7'd3, 7'd64, 7'd127, 7'd1,
                                                  7'd64, 7'd3, 7'd45, 7'd33};

    torus_mirror mirror = new();

    int unsigned cycle_count = 0;
    int          burst_left = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          window_left = 0;
    int          ready_mode = 0;
    int unsigned phase_cnt = 0;

    life_generation_torus u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .row_index     (row_index),
        .row_cells     (row_cells),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_row_index (out_row_index),
        .out_row_cells (out_row_cells),
        .last_row      (last_row)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // All inputs change in the NBA region of a rising edge, so the values read here at the
    // edge are the ones the block sampled. Every transfer on either channel is seen here.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready) begin
            mirror.take_request(req_type, row_index, row_cells);
        end
        if (rst_n && out_valid && out_ready) begin
            mirror.check_row(out_row_index, out_row_cells, last_row);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver. It switches between windows of steady readiness, random stalls, a slow
    // one-in-four pattern and light stalls. Once, after enough requests have gone in, it
    // refuses results for a long stretch while the sender keeps pushing, so the advance
    // pipeline backs up and in_ready has to drop.
    always @(posedge clk)
    begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!hold_done && mirror.requests_taken >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            out_ready <= 1'b0;
        end
        else begin
            if (window_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                window_left = $urandom_range(20, 120);
            end
            else begin
                window_left = window_left - 1;
            end
            case (ready_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= (phase_cnt[1:0] == 2'd0);
                default: out_ready <= ($urandom_range(0, 4) != 0);
            endcase
            phase_cnt = phase_cnt + 1;
        end
    end

    // Offers one request and returns at the edge where it was accepted. Requests come in
    // bursts; between bursts valid drops for a random gap. With no gap the next call raises
    // the payload in the same step, so valid stays high across back-to-back transfers.
    task automatic offer(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx,
                         input logic [CELLS_W-1:0] cells);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;
        in_valid  <= 1'b1;
        req_type  <= req;
        row_index <= idx;
        row_cells <= cells;
        do @(posedge clk); while (!in_ready);
    endtask

    // Lowers valid, waits for every owed row, then lets a write still in flight finish.
    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (mirror.due_rows.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the row size register, then the column size register; the block must be idle.
    task automatic write_sizes(input logic [SIZE_W-1:0] rows_val,
                               input logic [SIZE_W-1:0] cols_val);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ACTIVE_ROWS;
        cfg_data  <= rows_val;
        @(posedge clk);
        mirror.set_size(REG_ACTIVE_ROWS, rows_val);
        cfg_index <= REG_ACTIVE_COLS;
        cfg_data  <= cols_val;
        @(posedge clk);
        mirror.set_size(REG_ACTIVE_COLS, cols_val);
        cfg_we <= 1'b0;
    endtask

    // Row contents of varied density, so that patterns die, settle and grow.
    function automatic logic [CELLS_W-1:0] random_row();
        logic [CELLS_W-1:0] a;
        logic [CELLS_W-1:0] b;
        logic [CELLS_W-1:0] c;
        logic [CELLS_W-1:0] res;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case ($urandom_range(0, 6))
            0: res = a;
            1: res = a & b & c;
            2: res = a & b;
            3: res = a | b;
            4: res = 64'd1 << $urandom_range(0, 63);
            5: res = '0;
            default: res = '1;
        endcase
        return res;
    endfunction

    // Mostly seeds a few active rows and runs generations with reads in between; the rest
    // is noise over any request type and any row, the unused type among them.
    task automatic random_episode(inout int made);
        logic [REQ_W-1:0] req_pick;
        int rows_now;
        int n;
        int k;
        rows_now = mirror.rows_in_use();
        if ($urandom_range(0, 9) < 7) begin
            n = $urandom_range(2, 6);
            for (k = 0; k < n; k++) begin
                offer(REQ_WRITE, IDX_W'($urandom_range(0, rows_now - 1)), random_row());
                made++;
            end
            n = $urandom_range(1, 3);
            for (k = 0; k < n; k++) begin
                offer(REQ_ADVANCE, IDX_W'($urandom_range(0, 63)), {$urandom, $urandom});
                made++;
                if ($urandom_range(0, 1) == 1) begin
                    offer(REQ_READ, IDX_W'($urandom_range(0, rows_now - 1)),
                          {$urandom, $urandom});
                    made++;
                end
            end
        end
        else begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) begin
                req_pick = REQ_W'($urandom_range(0, 3));
                offer(req_pick, IDX_W'($urandom_range(0, 63)), random_row());
                if (req_pick != REQ_UNUSED) made++;
            end
        end
    endtask

    initial
    begin
        int made;
        int p;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset size of 32 by 32. The grid starts dead everywhere.
        offer(REQ_READ, 6'd0, '0);
        offer(REQ_READ, 6'd63, '0);
        // A full row keeps the bits beyond the active columns until a generation runs.
        offer(REQ_WRITE, 6'd0, '1);
        offer(REQ_READ, 6'd0, '0);
        // Row 63 lies outside the active rows and must survive every advance untouched.
        offer(REQ_WRITE, 6'd63, 64'hA5A5_5A5A_0FF0_F00F);
        offer(REQ_UNUSED, 6'd0, '0);
        offer(REQ_READ, 6'd0, '0);
        // A live row of 32 survives; the rows above and below it, 31 and 1, are born.
        offer(REQ_ADVANCE, 6'd0, '0);
        offer(REQ_READ, 6'd63, '0);
        // A vertical blinker across the row wrap and a horizontal one across the column wrap.
        offer(REQ_WRITE, 6'd31, 64'h80);
        offer(REQ_WRITE, 6'd0, 64'h80);
        offer(REQ_WRITE, 6'd1, 64'h80);
        offer(REQ_WRITE, 6'd5, 64'h8000_0003);
        offer(REQ_ADVANCE, 6'd0, '0);
        offer(REQ_ADVANCE, 6'd0, '0);
        // The index and cells of an advance are don't-care; drive them to all ones.
        offer(REQ_ADVANCE, 6'd63, '1);
        offer(REQ_WRITE, 6'd63, '1);
        offer(REQ_READ, 6'd63, '0);
        offer(REQ_READ, 6'd31, '0);
        wait_idle();

        // Random phases, one per size setting. Sizes change only while nothing is owed.
        for (p = 0; p < N_SETTINGS; p++) begin
            write_sizes(rows_plan[p], cols_plan[p]);
            made = 0;
            while (made < ITEMS_PER_PHASE) random_episode(made);
            wait_idle();
        end

        $display("Covered %0d requests: %0d writes, %0d reads, %0d advances, %0d unused codes,",
                 mirror.requests_taken, mirror.writes, mirror.reads, mirror.advances,
                 mirror.ignored);
        $display("and checked %0d row reports over %0d grid sizes with %0d mismatches.",
                 mirror.reports, N_SETTINGS + 1, mirror.errors);
        if (mirror.errors == 0 && mirror.due_rows.size() == 0) begin
            $display("[ OK ] regression clean");
        end
        else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/lgt_pkg.sv
src/lgt_ram.sv
src/lgt_cell.sv
src/life_generation_torus.sv
test/life_generation_torus_tb.sv
